[rtl/core/icp_pkg.sv]
// ----------------------------------------------------------------------------
// Inline cache type profiler package
// Field widths, item kinds and the saturating counter step.
// ----------------------------------------------------------------------------
`default_nettype none

package icp_pkg;

  localparam int CLASS_W = 32;
  localparam int COUNT_W = 32;
  localparam int SLOT_W  = 3;

  localparam logic KIND_RECORD  = 1'b0;
  localparam logic KIND_PROMOTE = 1'b1;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == '1) ? v : v + COUNT_W'(1);
  endfunction

endpackage

`default_nettype wire

[rtl/core/inline_cache_type_profiler.sv]
// A record looks its class up in the used ways, then scans them for the dominant way;
// a promote runs a selection scan and a swap per promoted position, then the final scan.
// One item at a time: busy stays high until the result is out, and every way
// visit goes through the single read port of the way table.
// Reset (rst, synchronous) empties the table, clears the send total and the
// megamorphic flag; the receiver cannot stall, so done is high for one cycle.
// ----------------------------------------------------------------------------
// Inline cache type profiler
// Type profile of one call site: way lookup, append, partial selection sort
// and dominant-way report, all on one shared scan counter and way-table read port.
// ----------------------------------------------------------------------------
`default_nettype none

module inline_cache_type_profiler #(
  parameter int MAX_WAYS     = 8,
  parameter int EMITTED_WAYS = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          kind,
  input  wire logic [icp_pkg::CLASS_W-1:0]   receiver_class,
  input  wire logic [icp_pkg::CLASS_W-1:0]   argument_class,
  output logic                               done,
  output logic                               hit,
  output logic                               inserted,
  output logic [icp_pkg::SLOT_W-1:0]         way_slot,
  output logic                               is_megamorphic,
  output logic                               is_monomorphic,
  output logic                               dominant_valid,
  output logic [icp_pkg::CLASS_W-1:0]        dominant_class,
  output logic [icp_pkg::CLASS_W-1:0]        dominant_arg_class,
  output logic [icp_pkg::COUNT_W-1:0]        dominant_count,
  output logic [icp_pkg::COUNT_W-1:0]        total_sends
);

  localparam int CLASS_W  = icp_pkg::CLASS_W;
  localparam int COUNT_W  = icp_pkg::COUNT_W;
  localparam int SLOT_W   = icp_pkg::SLOT_W;
  localparam int IDX_W    = $clog2(MAX_WAYS);
  localparam int CNT_W    = $clog2(MAX_WAYS + 1);
  localparam int EMIT_CAP = (EMITTED_WAYS < MAX_WAYS) ? EMITTED_WAYS : MAX_WAYS;

  typedef enum logic [2:0] {
    IDLE,
    LOOKUP,
    SELECT,
    SWAP,
    DOMINANT
  } state_t;

  state_t state;

  logic [CLASS_W-1:0] way_class     [MAX_WAYS];
  logic [CLASS_W-1:0] way_arg_class [MAX_WAYS];
  logic [COUNT_W-1:0] way_hits      [MAX_WAYS];

  logic [CNT_W-1:0]   ways_used;
  logic [COUNT_W-1:0] send_total;
  logic               mega_flag;

  logic [CLASS_W-1:0] rcls;
  logic [CLASS_W-1:0] acls;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   pos;
  logic               hit_r;
  logic               ins_r;
  logic [SLOT_W-1:0]  slot_r;

  logic [CLASS_W-1:0] best_cls;
  logic [CLASS_W-1:0] best_arg;
  logic [COUNT_W-1:0] best_hits;
  logic [IDX_W-1:0]   best_idx;

  logic [IDX_W-1:0]   idx;
  logic [CLASS_W-1:0] rd_cls;
  logic [CLASS_W-1:0] rd_arg;
  logic [COUNT_W-1:0] rd_hits;
  logic [CNT_W-1:0]   lim;
  logic               dom_ok;

  assign idx     = cnt[IDX_W-1:0];
  assign rd_cls  = way_class[idx];
  assign rd_arg  = way_arg_class[idx];
  assign rd_hits = way_hits[idx];
  assign lim     = (CNT_W'(EMIT_CAP) < ways_used) ? CNT_W'(EMIT_CAP) : ways_used;
  assign dom_ok  = !mega_flag && (ways_used != '0) && (send_total != '0);
  assign busy    = (state != IDLE);

  always_ff @(posedge clk) begin
    done <= 1'b0;
    case (state)
      IDLE: begin
        if (start) begin
          rcls   <= receiver_class;
          acls   <= argument_class;
          hit_r  <= 1'b0;
          ins_r  <= 1'b0;
          slot_r <= '0;
          cnt    <= '0;
          pos    <= '0;
          if (kind == icp_pkg::KIND_RECORD) begin
            send_total <= icp_pkg::sat_inc(send_total);
            state      <= LOOKUP;
          end else if (ways_used < CNT_W'(2)) begin
            state <= DOMINANT;
          end else begin
            state <= SELECT;
          end
        end
      end
      LOOKUP: begin
        if (cnt == ways_used) begin
          if (ways_used == CNT_W'(MAX_WAYS)) begin
            mega_flag <= 1'b1;
          end else begin
            way_class[ways_used[IDX_W-1:0]]     <= rcls;
            way_arg_class[ways_used[IDX_W-1:0]] <= acls;
            way_hits[ways_used[IDX_W-1:0]]      <= COUNT_W'(1);
            ways_used <= ways_used + CNT_W'(1);
            ins_r     <= 1'b1;
            slot_r    <= SLOT_W'(ways_used[IDX_W-1:0]);
          end
          cnt   <= '0;
          state <= DOMINANT;
        end else if (rd_cls == rcls) begin
          way_hits[idx]      <= icp_pkg::sat_inc(rd_hits);
          way_arg_class[idx] <= acls;
          hit_r  <= 1'b1;
          slot_r <= SLOT_W'(idx);
          cnt    <= '0;
          state  <= DOMINANT;
        end else begin
          cnt <= cnt + CNT_W'(1);
        end
      end
      SELECT: begin
        if (cnt == ways_used) begin
          cnt   <= pos;
          state <= SWAP;
        end else begin
          if ((cnt == pos) || (rd_hits > best_hits)) begin
            best_cls  <= rd_cls;
            best_arg  <= rd_arg;
            best_hits <= rd_hits;
            best_idx  <= idx;
          end
          cnt <= cnt + CNT_W'(1);
        end
      end
      SWAP: begin
        way_class[idx]          <= best_cls;
        way_arg_class[idx]      <= best_arg;
        way_hits[idx]           <= best_hits;
        way_class[best_idx]     <= rd_cls;
        way_arg_class[best_idx] <= rd_arg;
        way_hits[best_idx]      <= rd_hits;
        pos <= pos + CNT_W'(1);
        if (pos + CNT_W'(1) == lim) begin
          cnt   <= '0;
          state <= DOMINANT;
        end else begin
          cnt   <= pos + CNT_W'(1);
          state <= SELECT;
        end
      end
      DOMINANT: begin
        if (cnt == ways_used) begin
          done               <= 1'b1;
          hit                <= hit_r;
          inserted           <= ins_r;
          way_slot           <= slot_r;
          is_megamorphic     <= mega_flag;
          is_monomorphic     <= !mega_flag && (ways_used == CNT_W'(1));
          dominant_valid     <= dom_ok;
          dominant_class     <= dom_ok ? best_cls : '0;
          dominant_arg_class <= dom_ok ? best_arg : '0;
          dominant_count     <= dom_ok ? best_hits : '0;
          total_sends        <= send_total;
          state              <= IDLE;
        end else begin
          if ((cnt == '0) || (rd_hits > best_hits)) begin
            best_cls  <= rd_cls;
            best_arg  <= rd_arg;
            best_hits <= rd_hits;
            best_idx  <= idx;
          end
          cnt <= cnt + CNT_W'(1);
        end
      end
      default: begin
        state <= IDLE;
      end
    endcase
    if (rst) begin
      state      <= IDLE;
      done       <= 1'b0;
      ways_used  <= '0;
      send_total <= '0;
      mega_flag  <= 1'b0;
    end
  end

  a_done_after_scan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == DOMINANT)
    else $error("result strobe without a finished dominant scan");

  a_ways_bounded: assert property (@(posedge clk) disable iff (rst)
    ways_used <= CNT_W'(MAX_WAYS))
    else $error("way count beyond table depth");

  a_mega_sticky: assert property (@(posedge clk) disable iff (rst)
    mega_flag |=> mega_flag)
    else $error("megamorphic flag cleared without reset");

  a_hit_ins_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(hit && inserted))
    else $error("item both hit and inserted");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

endmodule

`default_nettype wire
